// ===== hw/rtl/spq_pkg.sv =====
// package for the sorted priority queue: depth, request/response payloads,
// slot and cell control types; no dependencies
package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_SORTED = 2'd0,
		FUNC_FRONT  = 2'd1,
		FUNC_BACK   = 2'd2,
		FUNC_POP    = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  entry_priority;
		logic [15:0] entry_tag;
		logic [11:0] entry_year;
	} req_t;

	typedef struct packed {
		logic        head_valid;
		logic [7:0]  head_priority;
		logic [15:0] head_tag;
		logic [11:0] head_year;
		logic [4:0]  occupancy;
		logic        full_drop;
		logic        empty_pop;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  pri;
		logic [15:0] tag;
		logic [11:0] year;
	} slot_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic  ins;
		logic  pop;
		logic  sorted;
		slot_t entry;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// one slot of the queue chain: holds an entry and shifts toward head or tail
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      mark_in,
	input  slot_t     left_slot,
	input  slot_t     right_slot,
	output logic      mark_out,
	output slot_t     slot_q
);

	// insert point is at or before this cell
	assign mark_out = mark_in | ~occupied | (ctl.sorted & (slot_q.pri > ctl.entry.pri));

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (mark_in) begin
				slot_q <= left_slot;
			end else if (mark_out) begin
				slot_q <= ctl.entry;
			end
		end else if (ctl.pop) begin
			slot_q <= right_slot;
		end
	end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// top level of the stable sorted priority queue: a chain of spq_cell slots
// plus count, control and response registers; depends on spq_pkg, spq_cell
//
// usage: one request is taken per clock while start is high (busy is always
// low, since every cell compares and shifts in the same cycle, so the rate is
// one request per cycle), and each request gives exactly one response, shown
// on rsp for one cycle with done high, after the done_s1 and done_s2 registers;
// the receiver cannot stall responses. a sorted insert goes in front of the
// first entry with greater priority, push front/back ignore priority, pop
// removes the head. rsp shows the head after the request (zeros when empty),
// the occupancy and the full_drop / empty_pop error flags. no clearing pass is
// needed after reset.
module sorted_priority_queue import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             empty;
	logic             accept;
	logic             is_pop;
	cell_ctl_t        ctl;
	slot_t            cell_slot [DEPTH];
	logic [DEPTH:0]   mark;

	logic             done_s1;
	logic             full_drop_s1;
	logic             empty_pop_s1;
	logic             done_s2;
	rsp_t             rsp_s2;

	// the chain never needs to hold off a request
	assign busy   = 1'b0;
	assign accept = start & ~busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign is_pop = (req.func == FUNC_POP);

	// control broadcast to all cells
	always_comb begin
		ctl.ins        = accept & ~is_pop & ~full;
		ctl.pop        = accept & is_pop & ~empty;
		ctl.sorted     = (req.func == FUNC_SORTED);
		ctl.entry.pri  = req.entry_priority;
		ctl.entry.tag  = req.entry_tag;
		ctl.entry.year = req.entry_year;
	end

	// push front places the insert point ahead of the first cell
	assign mark[0] = (req.func == FUNC_FRONT);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		slot_t left_slot;
		slot_t right_slot;

		// cell 0 takes the new entry from the left on push front
		if (i == 0) begin : g_first
			assign left_slot = ctl.entry;
		end else begin : g_mid
			assign left_slot = cell_slot[i-1];
		end

		// last cell has nothing on its right, it just goes unoccupied on pop
		if (i == DEPTH - 1) begin : g_last
			assign right_slot = cell_slot[i];
		end else begin : g_inner
			assign right_slot = cell_slot[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (count_q > CNT_W'(i)),
			.mark_in    (mark[i]),
			.left_slot  (left_slot),
			.right_slot (right_slot),
			.mark_out   (mark[i+1]),
			.slot_q     (cell_slot[i])
		);
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// stage 1: error flags, while the cells take the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		full_drop_s1 <= ~is_pop & full;
		empty_pop_s1 <= is_pop & empty;
	end

	// stage 2: sample the updated head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= done_s1;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s2.head_valid    <= ~empty;
		rsp_s2.head_priority <= empty ? 8'd0 : cell_slot[0].pri;
		rsp_s2.head_tag      <= empty ? 16'd0 : cell_slot[0].tag;
		rsp_s2.head_year     <= empty ? 12'd0 : cell_slot[0].year;
		rsp_s2.occupancy     <= 5'(count_q);
		rsp_s2.full_drop     <= full_drop_s1;
		rsp_s2.empty_pop     <= empty_pop_s1;
	end

	assign done = done_s2;
	assign rsp  = rsp_s2;

	// count stays within the chain length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	// an insert into a queue that is not full always finds its place in the chain
	a_insert_point: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |-> mark[DEPTH])
		else $error("insert found no place in the chain");

	// every accepted request raises done through the done_s1 and done_s2 registers
	a_resp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("response missing for accepted request");

	// a dropped insert happens on a full queue, so the head is valid and no empty pop is flagged
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.full_drop |-> rsp.head_valid && !rsp.empty_pop)
		else $error("full drop reported on a queue that is not full");

	// a pop on empty leaves the queue empty
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.empty_pop |-> !rsp.head_valid && rsp.occupancy == 5'd0)
		else $error("empty pop reported on a non-empty queue");

endmodule

// ===== sim/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the stable sorted priority queue: directed order cases,
// fill-to-full and drain, and biased random traffic checked against a queue-based predictor;
// depends on spq_pkg and sorted_priority_queue
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int LIMIT = 200_000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// predictor state: entries from head (index 0) to tail
	slot_t held_entries[$];
	// one expected response per accepted request, oldest first
	rsp_t expected_heads[$];

	int mismatches = 0;
	int cycle_count = 0;
	int requests_sent = 0;
	int responses_seen = 0;
	int func_count[4] = '{0, 0, 0, 0};
	int drop_count = 0;
	int empty_pop_count = 0;
	int peak_occupancy = 0;

	sorted_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles, %0d responses still pending",
				cycle_count, expected_heads.size());
			$display("sorted_priority_queue verification failed");
			$finish;
		end
	end

	// predicts one request: updates the held entries and returns the expected response
	function automatic rsp_t queue_step(req_t r);
		rsp_t res;
		slot_t e;
		int pos;
		res = '0;
		e = '{pri: r.entry_priority, tag: r.entry_tag, year: r.entry_year};
		func_count[int'(r.func)]++;
		if (r.func == FUNC_POP) begin
			if (held_entries.size() == 0) begin
				res.empty_pop = 1'b1;
				empty_pop_count++;
			end else begin
				void'(held_entries.pop_front());
			end
		end else if (held_entries.size() >= DEPTH) begin
			// any insert kind is dropped when full
			res.full_drop = 1'b1;
			drop_count++;
		end else begin
			case (r.func)
				FUNC_SORTED: begin
					// in front of the first entry with greater priority, counted from the head,
					// even when push front/back broke the order
					pos = 0;
					while (pos < held_entries.size() && held_entries[pos].pri <= e.pri)
						pos++;
					if (pos == held_entries.size())
						held_entries.push_back(e);
					else
						held_entries.insert(pos, e);
				end
				FUNC_FRONT: held_entries.push_front(e);
				default: held_entries.push_back(e);
			endcase
		end
		// head fields read as zero when nothing is held
		if (held_entries.size() > 0) begin
			res.head_valid = 1'b1;
			res.head_priority = held_entries[0].pri;
			res.head_tag = held_entries[0].tag;
			res.head_year = held_entries[0].year;
		end
		res.occupancy = 5'(held_entries.size());
		if (held_entries.size() > peak_occupancy)
			peak_occupancy = held_entries.size();
		return res;
	endfunction

	function automatic req_t make_req(func_t f, logic [7:0] p, logic [15:0] t, logic [11:0] y);
		req_t r;
		r.func = f;
		r.entry_priority = p;
		r.entry_tag = t;
		r.entry_year = y;
		return r;
	endfunction

	// random request; insert_pct sets the fill/drain bias, narrow_pri forces priority ties
	function automatic req_t rand_request(int insert_pct, bit narrow_pri);
		func_t f;
		int k;
		logic [7:0] p;
		if ($urandom_range(99) < insert_pct) begin
			k = $urandom_range(9);
			f = (k < 6) ? FUNC_SORTED : (k < 8) ? FUNC_FRONT : FUNC_BACK;
		end else begin
			f = FUNC_POP;
		end
		if (narrow_pri)
			p = 8'($urandom_range(3) * 85);
		else
			p = 8'($urandom_range(255));
		return make_req(f, p, 16'($urandom_range(16'hffff)), 12'($urandom_range(12'hfff)));
	endfunction

	// drives one request and waits for the accepting edge; start stays high on return
	task automatic send_request(input req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_heads.push_back(queue_step(r));
		requests_sent++;
	endtask

	// sender gap: drops start and waits, unless n is zero
	task automatic hold_off(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stops sending until every expected response has come back
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_heads.size() != 0);
	endtask

	function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s at response %0d: expected %h, got %h",
					field, responses_seen, want, got);
		end
	endfunction

	// response checker; done and rsp are sampled at the edge that ends their cycle
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_heads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response with no request pending: %h", rsp);
			end else begin
				want = expected_heads.pop_front();
				check_field("head_valid", 16'(want.head_valid), 16'(rsp.head_valid));
				check_field("head_priority", 16'(want.head_priority), 16'(rsp.head_priority));
				check_field("head_tag", want.head_tag, rsp.head_tag);
				check_field("head_year", 16'(want.head_year), 16'(rsp.head_year));
				check_field("occupancy", 16'(want.occupancy), 16'(rsp.occupancy));
				check_field("full_drop", 16'(want.full_drop), 16'(rsp.full_drop));
				check_field("empty_pop", 16'(want.empty_pop), 16'(rsp.empty_pop));
			end
			responses_seen++;
		end
	end

	// ordering corner cases, back to back
	task automatic test_order_cases();
		send_request(make_req(FUNC_POP, 8'h00, 16'h0000, 12'h000));     // pop on empty
		send_request(make_req(FUNC_SORTED, 8'h80, 16'hffff, 12'hfff));
		send_request(make_req(FUNC_SORTED, 8'h80, 16'h0001, 12'h001));  // tie stays behind
		send_request(make_req(FUNC_SORTED, 8'h00, 16'h0000, 12'h000));  // new head
		send_request(make_req(FUNC_SORTED, 8'hff, 16'haaaa, 12'haaa));
		send_request(make_req(FUNC_FRONT, 8'hff, 16'h5555, 12'h555));   // breaks the order
		send_request(make_req(FUNC_BACK, 8'h00, 16'h1234, 12'h123));    // low priority at tail
		// first greater entry is now the head, so this lands in front
		send_request(make_req(FUNC_SORTED, 8'h80, 16'h0f0f, 12'h0f0));
		send_request(make_req(FUNC_SORTED, 8'hff, 16'hf0f0, 12'hf0f)); // nothing greater: tail
		repeat (9) send_request(make_req(FUNC_POP, 8'hff, 16'hffff, 12'hfff));
		// front and back into an empty queue
		send_request(make_req(FUNC_FRONT, 8'h01, 16'hbeef, 12'h7ff));
		send_request(make_req(FUNC_POP, 8'h00, 16'h0000, 12'h000));
		send_request(make_req(FUNC_BACK, 8'hfe, 16'h8000, 12'h800));
		send_request(make_req(FUNC_POP, 8'h00, 16'h0000, 12'h000));
	endtask

	// fill to DEPTH, try every insert kind while full, then drain past empty
	task automatic test_full_queue();
		req_t r;
		repeat (DEPTH) begin
			r = rand_request(100, 1'($urandom_range(1)));
			send_request(r);
			hold_off($urandom_range(1));
		end
		send_request(make_req(FUNC_SORTED, 8'h00, 16'hffff, 12'hfff));
		send_request(make_req(FUNC_FRONT, 8'h00, 16'h0000, 12'h000));
		send_request(make_req(FUNC_BACK, 8'hff, 16'hffff, 12'hfff));
		send_request(make_req(FUNC_POP, 8'h00, 16'h0000, 12'h000));
		send_request(make_req(FUNC_BACK, 8'hff, 16'h7777, 12'h777));   // refills last slot
		send_request(make_req(FUNC_SORTED, 8'hff, 16'h6666, 12'h666));  // dropped again
		repeat (DEPTH + 1) begin
			send_request(make_req(FUNC_POP, 8'($urandom_range(255)), 16'h0, 12'h0));
			hold_off($urandom_range(2));
		end
	endtask

	// biased random phases: fill-heavy phases reach full, drain-heavy ones reach empty
	task automatic test_random_traffic(input int count);
		int insert_pct;
		int phase_left;
		int burst_left;
		bit narrow_pri;
		bit no_idle;
		req_t r;
		phase_left = 0;
		burst_left = 0;
		insert_pct = 50;
		narrow_pri = 1'b0;
		no_idle = 1'b0;
		repeat (count) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(80, 30);
				case ($urandom_range(3))
					0: insert_pct = 25;
					1: insert_pct = 50;
					2: insert_pct = 75;
					default: insert_pct = 92;
				endcase
				narrow_pri = ($urandom_range(2) == 0);
				no_idle = ($urandom_range(3) == 0);
			end
			phase_left--;
			r = rand_request(insert_pct, narrow_pri);
			send_request(r);
			// bursts separated by random gaps, none in idle-free phases
			if (burst_left == 0) begin
				burst_left = $urandom_range(20, 1);
				if (!no_idle)
					hold_off($urandom_range(5));
			end
			burst_left--;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_order_cases();
		test_full_queue();
		test_random_traffic(850);
		// let the queue's responses fully catch up once mid-run
		wait_drained();
		test_random_traffic(850);

		// drain, then wait out the response pipeline for stray responses
		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_heads.size() != 0) begin
			mismatches += expected_heads.size();
			$display("%0d expected responses never arrived", expected_heads.size());
		end

		$display("ran %0d requests (%0d sorted, %0d front, %0d back, %0d pop), %0d responses",
			requests_sent, func_count[0], func_count[1], func_count[2], func_count[3],
			responses_seen);
		$display("peak occupancy %0d, %0d full drops, %0d empty pops, %0d mismatches",
			peak_occupancy, drop_count, empty_pop_count, mismatches);
		if (mismatches == 0)
			$display("sorted_priority_queue verification clean");
		else
			$display("sorted_priority_queue verification failed");
		$finish;
	end

endmodule
